FILE: sv/mdu_pkg.sv
// Shared types and constants of the multiply/divide unit.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mdu_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned DivSteps = 32;
  localparam int unsigned CntW     = 5;

  typedef enum logic [2:0] {
    OP_MULT  = 3'd0,
    OP_MULTU = 3'd1,
    OP_DIV   = 3'd2,
    OP_DIVU  = 3'd3,
    OP_MFHI  = 3'd4,
    OP_MFLO  = 3'd5,
    OP_MTHI  = 3'd6,
    OP_MTLO  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [WordW-1:0] operand_a;
    logic [WordW-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] read_value;
    logic [WordW-1:0] hi_after;
    logic [WordW-1:0] lo_after;
  } out_item_t;

  // Decoded command: operands already turned into magnitudes for signed ops.
  typedef struct packed {
    op_e              op;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic             neg_q;
    logic             neg_r;
  } cmd_t;

endpackage

`default_nettype wire

FILE: sv/mdu_front.sv
// Front end: accepts input words, decodes the opcode and forms operand
// magnitudes and result sign flags. Depends on mdu_pkg.
`default_nettype none

module mdu_front (
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire mdu_pkg::in_item_t in_data_i,
  output logic                  cmd_valid_o,
  output mdu_pkg::cmd_t         cmd_o,
  input  wire logic             cmd_full_i
);

  mdu_pkg::op_e op;
  logic         signed_op;
  logic         a_neg;
  logic         b_neg;

  always_comb begin
    op        = mdu_pkg::op_e'(in_data_i.opcode);
    signed_op = (op == mdu_pkg::OP_MULT) || (op == mdu_pkg::OP_DIV);
    a_neg     = signed_op & in_data_i.operand_a[mdu_pkg::WordW-1];
    b_neg     = signed_op & in_data_i.operand_b[mdu_pkg::WordW-1];
    cmd_o.op    = op;
    cmd_o.a     = a_neg ? (~in_data_i.operand_a + 32'd1) : in_data_i.operand_a;
    cmd_o.b     = b_neg ? (~in_data_i.operand_b + 32'd1) : in_data_i.operand_b;
    cmd_o.neg_q = a_neg ^ b_neg;
    cmd_o.neg_r = a_neg;
  end

  assign cmd_valid_o = in_valid_i;
  assign in_stall_o  = cmd_full_i;

endmodule

`default_nettype wire

FILE: sv/mdu_fifo.sv
// Short command queue between front end and back end.
// Depends on mdu_pkg for the command type.
`default_nettype none

module mdu_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire mdu_pkg::cmd_t data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output mdu_pkg::cmd_t      data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mdu_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/mdu_back.sv
// Back end: executes queued commands, holds HI and LO, drives the output
// register. Combinational 32x32 multiply, radix-2 restoring divider. Depends on mdu_pkg.
`default_nettype none

module mdu_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  wire mdu_pkg::cmd_t  cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output mdu_pkg::out_item_t  out_data_o
);

  mdu_pkg::state_e    state_q, state_d;
  logic [mdu_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [mdu_pkg::WordW-1:0] hi_q, hi_d;
  logic [mdu_pkg::WordW-1:0] lo_q, lo_d;
  logic [mdu_pkg::WordW-1:0] rem_q, rem_d;
  logic [mdu_pkg::WordW-1:0] quo_q, quo_d;
  logic [mdu_pkg::WordW-1:0] den_q, den_d;
  mdu_pkg::cmd_t      cmd_q, cmd_d;
  logic               out_valid_q, out_valid_d;
  mdu_pkg::out_item_t out_q, out_d;

  logic               out_free;
  logic               is_mul;
  logic [mdu_pkg::WordW:0]     trial;
  logic [2*mdu_pkg::WordW-1:0] prod;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign is_mul      = (cmd_q.op == mdu_pkg::OP_MULT) || (cmd_q.op == mdu_pkg::OP_MULTU);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mdu_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            mdu_pkg::OP_MULT, mdu_pkg::OP_MULTU: state_d = mdu_pkg::ST_FIX;
            mdu_pkg::OP_DIV, mdu_pkg::OP_DIVU:   state_d = mdu_pkg::ST_DIV;
            default:                             state_d = mdu_pkg::ST_OUT;
          endcase
        end
      end
      mdu_pkg::ST_DIV: begin
        if (cnt_q == mdu_pkg::CntW'(mdu_pkg::DivSteps - 1)) begin
          state_d = mdu_pkg::ST_FIX;
        end
      end
      mdu_pkg::ST_FIX: state_d = mdu_pkg::ST_OUT;
      mdu_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = mdu_pkg::ST_IDLE;
        end
      end
      default: state_d = mdu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o   = 1'b0;
    cnt_d       = cnt_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    den_d       = den_q;
    cmd_d       = cmd_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    trial       = {rem_q, quo_q[mdu_pkg::WordW-1]} - {1'b0, den_q};
    prod        = {rem_q, quo_q};
    unique case (state_q)
      mdu_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          unique case (cmd_i.op)
            mdu_pkg::OP_MULT, mdu_pkg::OP_MULTU: begin
              {rem_d, quo_d} = (2*mdu_pkg::WordW)'(cmd_i.a) * (2*mdu_pkg::WordW)'(cmd_i.b);
            end
            mdu_pkg::OP_DIV, mdu_pkg::OP_DIVU: begin
              rem_d = '0;
              quo_d = cmd_i.a;
              den_d = cmd_i.b;
              cnt_d = '0;
            end
            mdu_pkg::OP_MTHI: hi_d = cmd_i.a;
            mdu_pkg::OP_MTLO: lo_d = cmd_i.a;
            default: begin
            end
          endcase
        end
      end
      mdu_pkg::ST_DIV: begin
        cnt_d = cnt_q + mdu_pkg::CntW'(1);
        if (!trial[mdu_pkg::WordW]) begin
          rem_d = trial[mdu_pkg::WordW-1:0];
          quo_d = {quo_q[mdu_pkg::WordW-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[mdu_pkg::WordW-2:0], quo_q[mdu_pkg::WordW-1]};
          quo_d = {quo_q[mdu_pkg::WordW-2:0], 1'b0};
        end
      end
      mdu_pkg::ST_FIX: begin
        if (is_mul) begin
          {hi_d, lo_d} = cmd_q.neg_q ? (~prod + 64'd1) : prod;
        end else begin
          lo_d = cmd_q.neg_q ? (~quo_q + 32'd1) : quo_q;
          hi_d = cmd_q.neg_r ? (~rem_q + 32'd1) : rem_q;
        end
      end
      mdu_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.hi_after  = hi_q;
          out_d.lo_after  = lo_q;
          unique case (cmd_q.op)
            mdu_pkg::OP_MFHI: out_d.read_value = hi_q;
            mdu_pkg::OP_MFLO: out_d.read_value = lo_q;
            default:          out_d.read_value = '0;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mdu_pkg::ST_IDLE;
      cnt_q       <= '0;
      hi_q        <= '0;
      lo_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      hi_q        <= hi_d;
      lo_q        <= lo_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    cmd_q <= cmd_d;
    out_q <= out_d;
  end

endmodule

`default_nettype wire

FILE: sv/mips_mult_div_unit.sv
// Multiply/divide unit with HI and LO registers: top level.
// Instantiates mdu_front, mdu_fifo and mdu_back; depends on mdu_pkg.
//
// Input channel in_valid_i / in_stall_o / in_data_i carries one word per
// operation (opcode, operand_a, operand_b). Output channel out_valid_o /
// out_stall_i / out_data_o returns one word per operation: the value read
// by mfhi/mflo (zero otherwise) and HI and LO after the operation.
// A word moves at a rising edge with valid high and stall low.
// Operations execute strictly in order. The front end decodes, the queue
// holds up to QueueDepth operations and the back end runs one at a time.
// Steps from input accept to output, with the queue empty:
//   moves:      queue write, dequeue, output register,
//   multiplies: one 32x32 multiply, then sign fix,
//   divides:    32 radix-2 restoring steps, then sign fix.
// Sustained throughput is set by the back end, which finishes each
// operation before it takes the next.
// When the receiver stalls, the output register holds its word and the
// back end waits with its next result; input keeps filling the queue and
// in_stall_o rises once the queue is full.
// Reset clears HI, LO, the queue and the output register's valid flag.
`default_nettype none

module mips_mult_div_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire mdu_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output mdu_pkg::out_item_t      out_data_o
);

  logic          push;
  logic          full;
  logic          pop;
  logic          q_valid;
  mdu_pkg::cmd_t cmd_in;
  mdu_pkg::cmd_t cmd_out;

  mdu_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (push),
    .cmd_o       (cmd_in),
    .cmd_full_i  (full)
  );

  mdu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (cmd_out)
  );

  mdu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
